// ===== src/pfrf_pkg.sv =====
// shared codes, constants and the page mask and mode apply functions for the paged framebuffer
`timescale 1ns / 1ps

package pfrf_pkg;

   localparam int ROWS_PER_PAGE = 8;
   localparam logic [7:0] FULL_MASK = 8'hFF;

   typedef enum logic [1:0] {
      REQ_FILL  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      MODE_SET    = 2'd0,
      MODE_INVERT = 2'd1,
      MODE_ERASE  = 2'd2,
      MODE_KEEP   = 2'd3
   } mode_code_type;

   // row mask of one page, cut at the top and bottom rows of the rectangle
   function automatic logic [7:0] page_mask(input logic [2:0] page,
                                            input logic [5:0] top,
                                            input logic [5:0] bottom);
      logic [7:0] m;
      m = FULL_MASK;
      if (page == top[5:3]) m = m & (FULL_MASK << top[2:0]);
      if (page == bottom[5:3]) m = m & (FULL_MASK >> (3'd7 - bottom[2:0]));
      return m;
   endfunction

   function automatic logic [7:0] apply_mode(input logic [1:0] mode,
                                             input logic [7:0] data,
                                             input logic [7:0] mask);
      logic [7:0] r;
      case (mode)
         MODE_SET:    r = data | mask;
         MODE_INVERT: r = data ^ mask;
         MODE_ERASE:  r = data & ~mask;
         default:     r = data;
      endcase
      return r;
   endfunction

endpackage

// ===== src/pfrf_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module pfrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/paged_framebuffer_rect_fill.sv =====
// top level: paged 1-bit framebuffer with rectangle fill, byte read and clear
`timescale 1ns / 1ps

// The pixel store is a PAGE_COUNT x COLUMN_COUNT byte ram, one byte per column
// of an 8-row page, bit 0 the top row. A request is taken when start is high
// and busy is low; its single result appears for one cycle with rsp_valid and
// must be taken then. A fill walks the rectangle one byte per cycle through the
// ram's read-modify-write path. A read answers from the READ state, once the
// ram's registered read data is ready. A rejected fill, a no-change fill or an
// unknown request answers in the cycle after it is taken. After reset, and for
// every clear request, the block sweeps the whole store to zero at one byte a
// cycle with busy high; a clear answers when its sweep ends.
module paged_framebuffer_rect_fill #(
   parameter int PAGE_COUNT   = 8,
   parameter int COLUMN_COUNT = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [5:0]  req_row_top,
   input  logic [6:0]  req_col_left,
   input  logic [5:0]  req_row_bottom,
   input  logic [6:0]  req_col_right,
   input  logic [1:0]  req_color_mode,
   input  logic [9:0]  req_read_addr,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic [10:0] rsp_bytes_touched,
   output logic        rsp_req_error
);

   localparam int STORE_BYTES = PAGE_COUNT * COLUMN_COUNT;
   localparam int AW = $clog2(STORE_BYTES);
   localparam int ROW_LIMIT = PAGE_COUNT * pfrf_pkg::ROWS_PER_PAGE;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_DRAIN,
      ST_READ
   } state_type;

   state_type   state_ff;
   logic [AW-1:0] clr_ff;
   logic        clr_rsp_ff;
   logic [6:0]  col_ff;
   logic [2:0]  page_ff;
   logic [AW-1:0] page_base_ff;
   logic [5:0]  top_ff;
   logic [5:0]  bottom_ff;
   logic [6:0]  left_ff;
   logic [6:0]  right_ff;
   logic [1:0]  mode_ff;
   logic [10:0] count_ff;
   logic        rd_ok_ff;
   logic        pend_ff;
   logic [AW-1:0] pend_addr_ff;
   logic [7:0]  pend_mask_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_read_data_ff;
   logic [10:0] rsp_bytes_ff;
   logic        rsp_error_ff;

   logic          accept;
   logic          fill_bad;
   logic          rd_in_range;
   logic [12:0]   rd_addr_wide;
   logic [AW-1:0] fill_addr;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);

   assign fill_bad = (req_row_bottom < req_row_top) || (req_col_right < req_col_left) ||
                     ({2'b0, req_row_bottom} >= 8'(ROW_LIMIT)) ||
                     ({2'b0, req_col_right} >= 9'(COLUMN_COUNT));
   assign rd_addr_wide = {3'b0, req_read_addr};
   assign rd_in_range = rd_addr_wide < 13'(STORE_BYTES);

   assign fill_addr = page_base_ff + AW'(col_ff);

   always_comb begin
      if (state_ff == ST_FILL) ram_rd_addr = fill_addr;
      else ram_rd_addr = rd_addr_wide[AW-1:0];
   end

   // write side: clearing sweep or the write-back of the byte read last cycle
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = 8'd0;
      end else begin
         ram_wr_en = pend_ff;
         ram_wr_addr = pend_addr_ff;
         ram_wr_data = pfrf_pkg::apply_mode(mode_ff, ram_rd_data, pend_mask_ff);
      end
   end

   pfrf_ram #(
      .WIDTH(8),
      .DEPTH(STORE_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         clr_rsp_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(STORE_BYTES - 1)) begin
                  clr_ff <= '0;
                  state_ff <= ST_IDLE;
                  if (clr_rsp_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_read_data_ff <= 8'd0;
                     rsp_bytes_ff <= 11'd0;
                     rsp_error_ff <= 1'b0;
                  end
                  clr_rsp_ff <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  rsp_read_data_ff <= 8'd0;
                  rsp_bytes_ff <= 11'd0;
                  rsp_error_ff <= 1'b0;
                  unique case (req_type)
                     pfrf_pkg::REQ_FILL: begin
                        if (fill_bad) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_error_ff <= 1'b1;
                        end else if (req_color_mode == pfrf_pkg::MODE_KEEP) begin
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_FILL;
                           top_ff <= req_row_top;
                           bottom_ff <= req_row_bottom;
                           left_ff <= req_col_left;
                           right_ff <= req_col_right;
                           mode_ff <= req_color_mode;
                           col_ff <= req_col_left;
                           page_ff <= req_row_top[5:3];
                           page_base_ff <= AW'(int'(req_row_top[5:3]) * COLUMN_COUNT);
                           count_ff <= 11'd0;
                        end
                     end
                     pfrf_pkg::REQ_READ: begin
                        state_ff <= ST_READ;
                        rd_ok_ff <= rd_in_range;
                     end
                     pfrf_pkg::REQ_CLEAR: begin
                        state_ff <= ST_CLEAR;
                        clr_rsp_ff <= 1'b1;
                     end
                     default: rsp_valid_ff <= 1'b1;
                  endcase
               end
            end
            ST_FILL: begin
               pend_ff <= 1'b1;
               pend_addr_ff <= fill_addr;
               pend_mask_ff <= pfrf_pkg::page_mask(page_ff, top_ff, bottom_ff);
               count_ff <= count_ff + 11'd1;
               if (col_ff == right_ff) begin
                  if (page_ff == bottom_ff[5:3]) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     col_ff <= left_ff;
                     page_ff <= page_ff + 3'd1;
                     page_base_ff <= page_base_ff + AW'(COLUMN_COUNT);
                  end
               end else begin
                  col_ff <= col_ff + 7'd1;
               end
            end
            ST_DRAIN: begin
               // last write-back lands at this edge
               state_ff <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
               rsp_bytes_ff <= count_ff;
            end
            ST_READ: begin
               state_ff <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
               rsp_read_data_ff <= rd_ok_ff ? ram_rd_data : 8'd0;
               rsp_error_ff <= !rd_ok_ff;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_bytes_touched = rsp_bytes_ff;
   assign rsp_req_error = rsp_error_ff;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the paged framebuffer rectangle fill block
`timescale 1ns / 1ps

module testbench;

   localparam int PAGES = 8;
   localparam int COLS  = 128;
   localparam int STORE = PAGES * COLS;

   typedef struct packed {
      pfrf_pkg::req_code_type  kind;
      logic [5:0]              top;
      logic [6:0]              left;
      logic [5:0]              bottom;
      logic [6:0]              right;
      pfrf_pkg::mode_code_type mode;
      logic [9:0]              addr;
   } fb_request_type;

   typedef struct packed {
      logic [7:0]  data;
      logic [10:0] touched;
      logic        err;
   } fb_reply_type;

   // shadow copy of the pixel store and the replies it predicts
   class pixel_mirror_type;
      logic [7:0]   shadow [STORE];
      fb_reply_type replies_due [$];
      int           failures;

      function new();
         foreach (shadow[i]) shadow[i] = 8'h00;
         failures = 0;
      endfunction

      function int outstanding();
         return replies_due.size();
      endfunction

      function void note_request(fb_request_type r);
         fb_reply_type want;
         logic [7:0]   rows;
         int           count;
         int           a;
         want  = '0;
         count = 0;
         case (r.kind)
            pfrf_pkg::REQ_FILL: begin
               if (r.bottom < r.top || r.right < r.left ||
                   int'(r.bottom) >= PAGES * pfrf_pkg::ROWS_PER_PAGE ||
                   int'(r.right) >= COLS) begin
                  want.err = 1'b1;
               end else if (r.mode != pfrf_pkg::MODE_KEEP) begin
                  for (int p = int'(r.top[5:3]); p <= int'(r.bottom[5:3]); p++) begin
                     rows = 8'hFF;
                     // trim the rows above the top edge and below the bottom edge
                     if (p == int'(r.top[5:3])) rows = rows & (8'hFF << r.top[2:0]);
                     if (p == int'(r.bottom[5:3]))
                        rows = rows & (8'hFF >> (3'd7 - r.bottom[2:0]));
                     for (int c = int'(r.left); c <= int'(r.right); c++) begin
                        a = p * COLS + c;
                        case (r.mode)
                           pfrf_pkg::MODE_SET:    shadow[a] = shadow[a] | rows;
                           pfrf_pkg::MODE_INVERT: shadow[a] = shadow[a] ^ rows;
                           default:               shadow[a] = shadow[a] & ~rows;
                        endcase
                        count++;
                     end
                  end
                  want.touched = count[10:0];
               end
            end
            pfrf_pkg::REQ_READ: begin
               if (int'(r.addr) < STORE) want.data = shadow[r.addr];
               else want.err = 1'b1;
            end
            pfrf_pkg::REQ_CLEAR: foreach (shadow[i]) shadow[i] = 8'h00;
            default: ;
         endcase
         replies_due.push_back(want);
      endfunction

      function void check_reply(fb_reply_type got);
         fb_reply_type want;
         if (replies_due.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected word: data %h touched %0d err %b",
                        got.data, got.touched, got.err);
            return;
         end
         want = replies_due.pop_front();
         if (got.data !== want.data || got.touched !== want.touched ||
             got.err !== want.err) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected data %h touched %0d err %b,",
                        want.data, want.touched, want.err,
                        " got data %h touched %0d err %b",
                        got.data, got.touched, got.err);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = '0;
   logic [5:0]  req_row_top = '0;
   logic [6:0]  req_col_left = '0;
   logic [5:0]  req_row_bottom = '0;
   logic [6:0]  req_col_right = '0;
   logic [1:0]  req_color_mode = '0;
   logic [9:0]  req_read_addr = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_data;
   logic [10:0] rsp_bytes_touched;
   logic        rsp_req_error;

   pixel_mirror_type mirror = new();
   fb_request_type   seen_req;
   fb_reply_type     seen_reply;

   paged_framebuffer_rect_fill #(
      .PAGE_COUNT(PAGES),
      .COLUMN_COUNT(COLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_row_top(req_row_top),
      .req_col_left(req_col_left),
      .req_row_bottom(req_row_bottom),
      .req_col_right(req_col_right),
      .req_color_mode(req_color_mode),
      .req_read_addr(req_read_addr),
      .rsp_valid(rsp_valid),
      .rsp_read_data(rsp_read_data),
      .rsp_bytes_touched(rsp_bytes_touched),
      .rsp_req_error(rsp_req_error)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // values seen here are the ones before this edge's updates
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            seen_reply.data    = rsp_read_data;
            seen_reply.touched = rsp_bytes_touched;
            seen_reply.err     = rsp_req_error;
            mirror.check_reply(seen_reply);
         end
         if (start && !busy) begin
            seen_req.kind   = pfrf_pkg::req_code_type'(req_type);
            seen_req.top    = req_row_top;
            seen_req.left   = req_col_left;
            seen_req.bottom = req_row_bottom;
            seen_req.right  = req_col_right;
            seen_req.mode   = pfrf_pkg::mode_code_type'(req_color_mode);
            seen_req.addr   = req_read_addr;
            mirror.note_request(seen_req);
         end
      end
   end

   function automatic fb_request_type rect(pfrf_pkg::req_code_type kind, int top, int left,
                                           int bottom, int right,
                                           pfrf_pkg::mode_code_type mode, int addr);
      fb_request_type r;
      r.kind   = kind;
      r.top    = top[5:0];
      r.left   = left[6:0];
      r.bottom = bottom[5:0];
      r.right  = right[6:0];
      r.mode   = mode;
      r.addr   = addr[9:0];
      return r;
   endfunction

   function automatic fb_request_type random_request();
      fb_request_type r;
      int             pick;
      int             span;
      r.kind   = pfrf_pkg::req_code_type'($urandom_range(0, 3));
      r.top    = 6'($urandom);
      r.left   = 7'($urandom);
      r.bottom = 6'($urandom);
      r.right  = 7'($urandom);
      r.mode   = pfrf_pkg::mode_code_type'($urandom_range(0, 3));
      r.addr   = 10'($urandom);
      pick     = int'($urandom_range(0, 99));
      if (pick < 55) begin
         // well-formed rectangle, mostly small to keep the walk short
         r.kind = pfrf_pkg::REQ_FILL;
         r.mode = ($urandom_range(0, 19) == 0) ? pfrf_pkg::MODE_KEEP :
                  pfrf_pkg::mode_code_type'($urandom_range(0, 2));
         if ($urandom_range(0, 39) == 0) begin
            r.top    = 6'($urandom_range(0, 7));
            r.bottom = 6'($urandom_range(56, 63));
            r.left   = 7'($urandom_range(0, 7));
            r.right  = 7'($urandom_range(120, 127));
         end else begin
            r.top    = 6'($urandom_range(0, 63));
            span     = (63 - int'(r.top) < 15) ? 63 - int'(r.top) : 15;
            r.bottom = 6'(int'(r.top) + int'($urandom_range(0, span)));
            r.left   = 7'($urandom_range(0, 127));
            span     = (127 - int'(r.left) < 20) ? 127 - int'(r.left) : 20;
            r.right  = 7'(int'(r.left) + int'($urandom_range(0, span)));
         end
      end else if (pick < 63) begin
         r.kind = pfrf_pkg::REQ_FILL;
      end else if (pick < 93) begin
         r.kind = pfrf_pkg::REQ_READ;
      end else if (pick < 96) begin
         r.kind = pfrf_pkg::REQ_CLEAR;
      end else begin
         r.kind = pfrf_pkg::REQ_NONE;
      end
      return r;
   endfunction

   // called at a rising edge; returns at the edge that takes the word
   task automatic issue(fb_request_type r);
      req_type       <= r.kind;
      req_row_top    <= r.top;
      req_col_left   <= r.left;
      req_row_bottom <= r.bottom;
      req_col_right  <= r.right;
      req_color_mode <= r.mode;
      req_read_addr  <= r.addr;
      start          <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // the sender stays idle in about idle_pct cycles of a hundred
   task automatic random_phase(int count, int idle_pct);
      for (int i = 0; i < count; i++) begin
         while (int'($urandom_range(0, 99)) < idle_pct) begin
            start <= 1'b0;
            @(posedge clock);
         end
         issue(random_request());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      issue(rect(pfrf_pkg::REQ_FILL, 0, 0, 63, 127, pfrf_pkg::MODE_SET, 0));
      issue(rect(pfrf_pkg::REQ_READ, 0, 0, 0, 0, pfrf_pkg::MODE_SET, 0));
      issue(rect(pfrf_pkg::REQ_READ, 63, 127, 63, 127, pfrf_pkg::MODE_KEEP, 1023));
      issue(rect(pfrf_pkg::REQ_FILL, 0, 0, 0, 0, pfrf_pkg::MODE_INVERT, 0));
      issue(rect(pfrf_pkg::REQ_READ, 0, 0, 0, 0, pfrf_pkg::MODE_SET, 0));
      issue(rect(pfrf_pkg::REQ_FILL, 63, 127, 63, 127, pfrf_pkg::MODE_ERASE, 0));
      issue(rect(pfrf_pkg::REQ_READ, 0, 0, 0, 0, pfrf_pkg::MODE_SET, 1023));
      // straddles the first page boundary with both edges cut
      issue(rect(pfrf_pkg::REQ_FILL, 5, 10, 13, 20, pfrf_pkg::MODE_INVERT, 0));
      issue(rect(pfrf_pkg::REQ_READ, 0, 0, 0, 0, pfrf_pkg::MODE_SET, 10));
      issue(rect(pfrf_pkg::REQ_READ, 0, 0, 0, 0, pfrf_pkg::MODE_SET, COLS + 20));
      issue(rect(pfrf_pkg::REQ_FILL, 2, 0, 5, 127, pfrf_pkg::MODE_ERASE, 0));
      issue(rect(pfrf_pkg::REQ_READ, 0, 0, 0, 0, pfrf_pkg::MODE_SET, 0));
      issue(rect(pfrf_pkg::REQ_FILL, 9, 0, 8, 0, pfrf_pkg::MODE_SET, 0));
      issue(rect(pfrf_pkg::REQ_FILL, 0, 5, 0, 4, pfrf_pkg::MODE_SET, 0));
      issue(rect(pfrf_pkg::REQ_FILL, 0, 0, 63, 127, pfrf_pkg::MODE_KEEP, 0));
      issue(rect(pfrf_pkg::REQ_NONE, 63, 127, 63, 127, pfrf_pkg::MODE_KEEP, 1023));
      issue(rect(pfrf_pkg::REQ_CLEAR, 63, 127, 0, 0, pfrf_pkg::MODE_KEEP, 1023));
      issue(rect(pfrf_pkg::REQ_READ, 0, 0, 0, 0, pfrf_pkg::MODE_SET, 1023));
      issue(rect(pfrf_pkg::REQ_READ, 0, 0, 0, 0, pfrf_pkg::MODE_SET, 512));
      issue(rect(pfrf_pkg::REQ_FILL, 56, 127, 63, 127, pfrf_pkg::MODE_SET, 0));
      issue(rect(pfrf_pkg::REQ_READ, 0, 0, 0, 0, pfrf_pkg::MODE_SET, 7 * COLS + 127));
      issue(rect(pfrf_pkg::REQ_FILL, 0, 0, 0, 127, pfrf_pkg::MODE_SET, 0));
      issue(rect(pfrf_pkg::REQ_READ, 0, 0, 0, 0, pfrf_pkg::MODE_SET, 64));

      random_phase(530, 33);
      random_phase(530, 50);
      random_phase(530, 0);
      start <= 1'b0;

      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mirror.failures == 0 && mirror.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
src/pfrf_pkg.sv
src/pfrf_ram.sv
src/paged_framebuffer_rect_fill.sv
tb/testbench.sv
